### rtl/bpa_pkg.sv
// Package with types and constants shared by the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 65536;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned ADDR_W         = 28;
  localparam int unsigned CFG_W          = 14;
  localparam int unsigned RST_BYTES      = 8192;
  localparam int unsigned WORD_W         = 64;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_OOM   = 2'd1,
    STS_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } out_beat_t;

endpackage

### rtl/bitmap_page_allocator_unit.sv
// Bitmap page frame allocator, first fit, with the used map in one synchronous RAM.
`timescale 1ns / 1ps
// First-fit page frame allocator. One used bit per page sits in a RAM of
// MAX_PAGES/64 words of 64 bits. After reset the block sweeps the RAM to all
// ones (every page used), one word per cycle, and holds in_stall high
// meanwhile; configuration writes are taken at any time. Free and reserve
// do one RAM read and one write back between the accepted beat and the
// result beat. Allocate reads one word per cycle through the RAM port and
// checks it in the next cycle with a first-zero encoder; it answers on the
// first hit, or with out-of-memory once the last of the nwords words in
// range has been checked. One item is in flight at a time; the result
// register lets the next beat be accepted while the previous result still
// waits on out_stall.
module bitmap_page_allocator_unit #(
  parameter int unsigned MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bpa_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bpa_pkg::out_beat_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpa_pkg::CFG_W-1:0]  cfg_data
);

  localparam int unsigned PB_LOG    = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W    = $clog2(MAX_PAGES);
  localparam int unsigned LIM_W     = PAGE_W + 1;
  localparam int unsigned MAP_WORDS = MAX_PAGES / 64;
  localparam int unsigned AW        = (PAGE_W > 6) ? PAGE_W - 6 : 1;
  localparam int unsigned PGI_W     = bpa_pkg::ADDR_W - PB_LOG;
  localparam int unsigned CPW       = (PGI_W > LIM_W) ? PGI_W : LIM_W;
  localparam int unsigned CW        = (LIM_W > bpa_pkg::CFG_W) ? LIM_W : bpa_pkg::CFG_W;
  localparam int unsigned MAX_BYTES = MAX_PAGES / 8;
  localparam int unsigned RST_LIMIT =
    ((bpa_pkg::RST_BYTES > MAX_BYTES) ? MAX_BYTES : bpa_pkg::RST_BYTES) * 8;
  localparam int unsigned WW        = bpa_pkg::WORD_W;

  // used map
  logic [WW-1:0] mem [MAP_WORDS];
  logic [WW-1:0] mem_rd_r;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;

  bpa_pkg::state_t    state_r, state_nxt;
  logic [LIM_W-1:0]   limit_r, limit_nxt;
  logic [AW-1:0]      init_r, init_nxt;
  logic [AW:0]        issue_r, issue_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]      chk_w_r, chk_w_nxt;
  logic [AW-1:0]      tgt_w_r, tgt_w_nxt;
  logic [5:0]         tgt_b_r, tgt_b_nxt;
  logic               tgt_set_r, tgt_set_nxt;
  bpa_pkg::out_beat_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  bpa_pkg::out_beat_t out_data_r, out_data_nxt;

  logic               in_acc;
  logic [CW-1:0]      cfg_ext;
  logic [AW:0]        full_words;
  logic [5:0]         tail;
  logic [AW:0]        nwords;
  logic [WW-1:0]      range_mask;
  logic [WW-1:0]      free_bits;
  logic               found;
  logic [5:0]         hit_bit;
  logic [63:0]        hit_addr_wide;
  logic [PGI_W-1:0]   in_page;
  logic               in_oor;
  logic               resp_load;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != bpa_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // page limit follows the byte count, clamped to the map size
  assign cfg_ext   = CW'(cfg_data);
  assign limit_nxt = (cfg_ext > CW'(MAX_BYTES)) ? LIM_W'(MAX_PAGES)
                                                : LIM_W'({cfg_ext, 3'b000});

  assign full_words = (AW+1)'(limit_r >> 6);
  assign tail       = limit_r[5:0];
  assign nwords     = full_words + (AW+1)'(tail != 6'd0);

  assign in_page = in_data.address[bpa_pkg::ADDR_W-1:PB_LOG];
  assign in_oor  = (CPW'(in_page) >= CPW'(limit_r));

  // first clear bit of the checked word among pages in range
  assign range_mask = ((AW+1)'(chk_w_r) < full_words) ? {WW{1'b1}}
                                                      : ((WW'(1) << tail) - WW'(1));
  assign free_bits  = ~mem_rd_r & range_mask;
  assign found      = |free_bits;

  always_comb begin
    hit_bit = 6'd0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_bit = 6'(i);
      end
    end
  end

  assign hit_addr_wide = ((64'(chk_w_r) << 6) | 64'(hit_bit)) << PB_LOG;

  assign resp_load = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpa_pkg::ST_INIT: begin
        if (init_r == AW'(MAP_WORDS - 1)) state_nxt = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.op)
            bpa_pkg::OP_ALLOC: begin
              state_nxt = (nwords == '0) ? bpa_pkg::ST_RESP : bpa_pkg::ST_SCAN;
            end
            bpa_pkg::OP_FREE, bpa_pkg::OP_RESERVE: begin
              state_nxt = in_oor ? bpa_pkg::ST_RESP : bpa_pkg::ST_RMW_RD;
            end
            default: state_nxt = bpa_pkg::ST_RESP;
          endcase
        end
      end
      bpa_pkg::ST_SCAN: begin
        if (chk_vld_r && (found || (AW+1)'(chk_w_r) == nwords - (AW+1)'(1))) begin
          state_nxt = bpa_pkg::ST_RESP;
        end
      end
      bpa_pkg::ST_RMW_RD: state_nxt = bpa_pkg::ST_RMW_WR;
      bpa_pkg::ST_RMW_WR: state_nxt = bpa_pkg::ST_RESP;
      bpa_pkg::ST_RESP: begin
        if (resp_load) state_nxt = bpa_pkg::ST_IDLE;
      end
      default: state_nxt = bpa_pkg::ST_INIT;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    mem_re        = 1'b0;
    mem_ra        = tgt_w_r;
    mem_we        = 1'b0;
    mem_wa        = tgt_w_r;
    mem_wd        = mem_rd_r;
    init_nxt      = init_r;
    issue_nxt     = issue_r;
    chk_vld_nxt   = 1'b0;
    chk_w_nxt     = chk_w_r;
    tgt_w_nxt     = tgt_w_r;
    tgt_b_nxt     = tgt_b_r;
    tgt_set_nxt   = tgt_set_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      bpa_pkg::ST_INIT: begin
        mem_we   = 1'b1;
        mem_wa   = init_r;
        mem_wd   = {WW{1'b1}};
        init_nxt = init_r + AW'(1);
      end
      bpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          issue_nxt            = '0;
          tgt_w_nxt            = AW'(in_page >> 6);
          tgt_b_nxt            = 6'(in_page);
          tgt_set_nxt          = (in_data.op == bpa_pkg::OP_RESERVE);
          res_nxt.page_address = '0;
          res_nxt.status       = bpa_pkg::STS_OK;
          case (in_data.op)
            bpa_pkg::OP_ALLOC: begin
              if (nwords == '0) res_nxt.status = bpa_pkg::STS_OOM;
            end
            bpa_pkg::OP_FREE, bpa_pkg::OP_RESERVE: begin
              if (in_oor) res_nxt.status = bpa_pkg::STS_RANGE;
            end
            default: res_nxt.status = bpa_pkg::STS_OK;
          endcase
        end
      end
      bpa_pkg::ST_SCAN: begin
        // keep one read ahead of the check
        if (issue_r < nwords) begin
          mem_re      = 1'b1;
          mem_ra      = AW'(issue_r);
          issue_nxt   = issue_r + (AW+1)'(1);
          chk_vld_nxt = 1'b1;
          chk_w_nxt   = AW'(issue_r);
        end
        if (chk_vld_r) begin
          if (found) begin
            mem_we               = 1'b1;
            mem_wa               = chk_w_r;
            mem_wd               = mem_rd_r | (WW'(1) << hit_bit);
            res_nxt.page_address = hit_addr_wide[bpa_pkg::ADDR_W-1:0];
            res_nxt.status       = bpa_pkg::STS_OK;
          end else if ((AW+1)'(chk_w_r) == nwords - (AW+1)'(1)) begin
            res_nxt.status = bpa_pkg::STS_OOM;
          end
        end
      end
      bpa_pkg::ST_RMW_RD: begin
        mem_re = 1'b1;
        mem_ra = tgt_w_r;
      end
      bpa_pkg::ST_RMW_WR: begin
        mem_we = 1'b1;
        mem_wa = tgt_w_r;
        mem_wd = tgt_set_r ? (mem_rd_r | (WW'(1) << tgt_b_r))
                           : (mem_rd_r & ~(WW'(1) << tgt_b_r));
      end
      bpa_pkg::ST_RESP: begin
        if (resp_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        init_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::ST_INIT;
      limit_r     <= LIM_W'(RST_LIMIT);
      init_r      <= '0;
      issue_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= limit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_w_r    <= chk_w_nxt;
    tgt_w_r    <= tgt_w_nxt;
    tgt_b_r    <= tgt_b_nxt;
    tgt_set_r  <= tgt_set_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpa_pkg::ST_SCAN) |-> (issue_r <= nwords))
    else $error("scan issued past the words in range");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bpa_pkg::ST_RESP))
    else $error("result beat raised outside the response state");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != bpa_pkg::STS_OK) |-> (out_data_r.page_address == '0))
    else $error("failed result carries a page address");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != bpa_pkg::ST_IDLE))
    else $error("accepted beat left the block idle");

endmodule
